// ===== design/rlpd_pkg.sv =====
// Package for the length-prefixed record deframer.
// Holds the parse phase type, result kind and error codes, and field sizes.
// No dependencies.
package rlpd_pkg;

  // Byte counts of the fixed-size header fields.
  localparam logic [31:0] StampBytes = 32'd8;
  localparam logic [31:0] LenBytes   = 32'd4;

  // Parse phase of the current record.
  typedef enum logic [2:0] {
    PH_STAMP  = 3'd0,
    PH_SLEN   = 3'd1,
    PH_SENDER = 3'd2,
    PH_BLEN   = 3'd3,
    PH_BODY   = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  // Kind of a result item.
  typedef enum logic [2:0] {
    K_STAMP = 3'd0,
    K_SLEN  = 3'd1,
    K_SBYTE = 3'd2,
    K_BLEN  = 3'd3,
    K_BBYTE = 3'd4,
    K_ERROR = 3'd5
  } kind_t;

  // Error reported with a result item.
  typedef enum logic [1:0] {
    E_NONE   = 2'd0,
    E_HEADER = 2'd1,
    E_SENDER = 2'd2,
    E_BODY   = 2'd3
  } err_t;

endpackage

// ===== design/record_length_prefixed_deframer.sv =====
// Top level of the length-prefixed record deframer.
// Parses a byte stream into timestamp, lengths and payload bytes.
// Depends on rlpd_pkg.
//
// Usage:
//   The input channel (in_*) carries one buffer byte per transaction in
//   in_tdata; in_tlast marks the last byte of a buffer. Each buffer holds one
//   record: a big-endian 64-bit timestamp, a 32-bit sender length, the sender
//   bytes, a 32-bit body length and the body bytes.
//   The output channel (out_*) carries at most one result per input byte:
//   the completed timestamp, each length, or a payload byte, tagged by kind
//   in out_tuser together with an error code. out_tlast marks the result that
//   completes the record. Bytes after the body give no result.
//   The result is registered and appears in the cycle after the input
//   transaction. A new byte is accepted every cycle while in_tready is high;
//   the one-byte header state update and shift is the only work, and a single
//   output register holds the result. When the receiver stalls, the output
//   register holds its result and the input is still accepted if the register
//   is empty or being drained in the same cycle; otherwise in_tready falls.
//   Reset (rst_n low, synchronous) empties the output register and puts the
//   parser at the start of a timestamp. The parser also restarts after every
//   byte marked with in_tlast.
module record_length_prefixed_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // buffer_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] item_value
  output logic [4:0]  out_tuser,  // [2:0] item_kind, [4:3] error_code
  output logic        out_tlast   // record_end
);
  import rlpd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] left_r, left_nxt;
  logic [63:0] acc_r, acc_nxt;

  logic        out_valid_r;
  kind_t       kind_r;
  err_t        err_r;
  logic [63:0] value_r;
  logic        end_r;

  logic        in_fire;
  logic        res_valid;
  kind_t       res_kind;
  err_t        res_err;
  logic [63:0] res_value;
  logic        res_end;

  logic [63:0] acc_shift;
  logic [31:0] left_dec;
  logic [31:0] len;

  // Accept while the output register is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign acc_shift = {acc_r[55:0], in_tdata};
  assign left_dec  = (left_r != 32'd0) ? left_r - 32'd1 : 32'd0;
  assign len       = acc_shift[31:0];

  // Next parser state and the result for the incoming byte.
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    res_valid = 1'b0;
    res_kind  = K_ERROR;
    res_err   = E_NONE;
    res_value = 64'd0;
    res_end   = 1'b0;
    unique case (phase_r)
      PH_STAMP, PH_SLEN, PH_BLEN: begin
        acc_nxt  = acc_shift;
        left_nxt = left_dec;
        if (left_dec != 32'd0) begin
          // Field still incomplete: only a buffer end gives a result.
          if (in_tlast) begin
            res_valid = 1'b1;
            res_kind  = K_ERROR;
            res_err   = E_HEADER;
          end
        end else begin
          res_valid = 1'b1;
          acc_nxt   = 64'd0;
          if (phase_r == PH_STAMP) begin
            res_kind  = K_STAMP;
            res_value = acc_shift;
            res_err   = in_tlast ? E_HEADER : E_NONE;
            phase_nxt = PH_SLEN;
            left_nxt  = LenBytes;
          end else if (phase_r == PH_SLEN) begin
            res_kind  = K_SLEN;
            res_value = {32'd0, len};
            if (len != 32'd0) begin
              res_err   = in_tlast ? E_SENDER : E_NONE;
              phase_nxt = PH_SENDER;
              left_nxt  = len;
            end else begin
              // Empty sender: go straight to the body length.
              res_err   = in_tlast ? E_HEADER : E_NONE;
              phase_nxt = PH_BLEN;
              left_nxt  = LenBytes;
            end
          end else begin
            res_kind  = K_BLEN;
            res_value = {32'd0, len};
            if (len != 32'd0) begin
              res_err   = in_tlast ? E_BODY : E_NONE;
              phase_nxt = PH_BODY;
              left_nxt  = len;
            end else begin
              // Empty body: the length itself completes the record.
              res_end   = 1'b1;
              phase_nxt = PH_DONE;
              left_nxt  = 32'd0;
            end
          end
        end
      end
      PH_SENDER: begin
        res_valid = 1'b1;
        res_kind  = K_SBYTE;
        res_value = {56'd0, in_tdata};
        left_nxt  = left_dec;
        if (left_dec != 32'd0) begin
          res_err = in_tlast ? E_SENDER : E_NONE;
        end else begin
          res_err   = in_tlast ? E_HEADER : E_NONE;
          phase_nxt = PH_BLEN;
          left_nxt  = LenBytes;
          acc_nxt   = 64'd0;
        end
      end
      PH_BODY: begin
        res_valid = 1'b1;
        res_kind  = K_BBYTE;
        res_value = {56'd0, in_tdata};
        left_nxt  = left_dec;
        if (left_dec != 32'd0) begin
          res_err = in_tlast ? E_BODY : E_NONE;
        end else begin
          res_end   = 1'b1;
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        // Trailing bytes after the record are dropped.
      end
    endcase
    // The end of a buffer restarts the parser.
    if (in_tlast) begin
      phase_nxt = PH_STAMP;
      left_nxt  = StampBytes;
      acc_nxt   = 64'd0;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STAMP;
      left_r  <= StampBytes;
      acc_r   <= 64'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_fire && res_valid;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      kind_r  <= res_kind;
      err_r   <= res_err;
      value_r <= res_value;
      end_r   <= res_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = value_r;
  assign out_tuser  = {err_r, kind_r};
  assign out_tlast  = end_r;

  // A completed record is marked only on a length or body byte, error free.
  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      ((kind_r == K_BLEN || kind_r == K_BBYTE) && err_r == E_NONE))
    else $error("record end on wrong kind or with error");

  // An error-only result carries a header underrun and no value.
  a_err_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && kind_r == K_ERROR) |-> (err_r == E_HEADER && value_r == 64'd0))
    else $error("malformed error-only result");

  // After a buffer end the parser waits for a fresh timestamp.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=>
      (phase_r == PH_STAMP && left_r == StampBytes && acc_r == 64'd0))
    else $error("parser did not restart after buffer end");

  // Payload phases always have bytes outstanding.
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SENDER || phase_r == PH_BODY) |-> (left_r != 32'd0))
    else $error("payload phase with no bytes left");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for record_length_prefixed_deframer: random and directed
// buffers in, every result compared against a built-in parser model.
// Depends on rlpd_pkg and the deframer RTL.
module tb;
  import rlpd_pkg::*;

  // One expected result transaction.
  typedef struct {
    kind_t       kind;
    logic [63:0] value;
    err_t        err;
    logic        rec_end;
  } deframe_item_t;

  // Tracks the parser state, predicts results and checks the output stream.
  class record_tracker;
    phase_t        phase;
    logic [31:0]   left;
    logic [63:0]   acc;
    deframe_item_t expected_items[$];
    int            fails;
    int            checked;
    int            error_items;
    int            records_done;

    function new();
      fails = 0;
      checked = 0;
      error_items = 0;
      records_done = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_STAMP;
      left  = StampBytes;
      acc   = '0;
    endfunction

    function void queue_result(kind_t k, logic [63:0] v, err_t e, logic r);
      deframe_item_t it;
      it.kind    = k;
      it.value   = v;
      it.err     = e;
      it.rec_end = r;
      expected_items.insert(expected_items.size(), it);
    endfunction

    // Advances the parser by one accepted input byte.
    function void note_byte(logic [7:0] b, logic last);
      logic [31:0] len;
      case (phase)
        PH_STAMP, PH_SLEN, PH_BLEN: begin
          acc = {acc[55:0], b};
          if (left != 0) left--;
          if (left != 0) begin
            // Buffer ended inside a fixed-size header field.
            if (last) queue_result(K_ERROR, '0, E_HEADER, 1'b0);
          end else begin
            len = acc[31:0];
            if (phase == PH_STAMP) begin
              queue_result(K_STAMP, acc, last ? E_HEADER : E_NONE, 1'b0);
              phase = PH_SLEN;
              left  = LenBytes;
            end else if (phase == PH_SLEN) begin
              queue_result(K_SLEN, {32'd0, len},
                           last ? ((len != 0) ? E_SENDER : E_HEADER) : E_NONE, 1'b0);
              if (len != 0) begin
                phase = PH_SENDER;
                left  = len;
              end else begin
                phase = PH_BLEN;
                left  = LenBytes;
              end
            end else if (len != 0) begin
              queue_result(K_BLEN, {32'd0, len}, last ? E_BODY : E_NONE, 1'b0);
              phase = PH_BODY;
              left  = len;
            end else begin
              // An empty body completes the record right here.
              queue_result(K_BLEN, '0, E_NONE, 1'b1);
              phase = PH_DONE;
              left  = '0;
            end
            acc = '0;
          end
        end
        PH_SENDER: begin
          if (left != 0) left--;
          if (left != 0) begin
            queue_result(K_SBYTE, {56'd0, b}, last ? E_SENDER : E_NONE, 1'b0);
          end else begin
            queue_result(K_SBYTE, {56'd0, b}, last ? E_HEADER : E_NONE, 1'b0);
            phase = PH_BLEN;
            left  = LenBytes;
            acc   = '0;
          end
        end
        PH_BODY: begin
          if (left != 0) left--;
          if (left != 0) begin
            queue_result(K_BBYTE, {56'd0, b}, last ? E_BODY : E_NONE, 1'b0);
          end else begin
            queue_result(K_BBYTE, {56'd0, b}, E_NONE, 1'b1);
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
      if (last) restart();
    endfunction

    // Compares one accepted result transaction with the oldest expectation.
    function void check_item(logic [2:0] k, logic [63:0] v, logic [1:0] e, logic r);
      deframe_item_t exp_it;
      if (expected_items.size() == 0) begin
        $display("%0t: unexpected result, kind %0d value %h err %0d end %0d",
                 $time, k, v, e, r);
        fails++;
        return;
      end
      exp_it = expected_items.pop_front();
      checked++;
      if (exp_it.err != E_NONE) error_items++;
      if (exp_it.rec_end) records_done++;
      if (k !== exp_it.kind) begin
        $display("%0t: kind mismatch, expected %0d, actual %0d", $time, exp_it.kind, k);
        fails++;
      end
      if (v !== exp_it.value) begin
        $display("%0t: value mismatch, expected %h, actual %h", $time, exp_it.value, v);
        fails++;
      end
      if (e !== exp_it.err) begin
        $display("%0t: error code mismatch, expected %0d, actual %0d",
                 $time, exp_it.err, e);
        fails++;
      end
      if (r !== exp_it.rec_end) begin
        $display("%0t: record end mismatch, expected %0d, actual %0d",
                 $time, exp_it.rec_end, r);
        fails++;
      end
    endfunction
  endclass

  // Receiver stall patterns.
  typedef enum {RX_OPEN, RX_COIN, RX_RARE_STALL, RX_PERIODIC} rx_mode_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  record_tracker tracker = new();
  logic [7:0]    frame_bytes[$];
  int            bytes_sent   = 0;
  int            buffers_sent = 0;
  int            burst_left   = 0;
  bit            hold_done    = 1'b0;

  record_length_prefixed_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  // Appends one byte to the buffer under construction.
  function automatic void add_byte(logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endfunction

  // Lays out one buffer; payload bytes are capped so huge lengths stay short.
  function automatic void build_record(logic [63:0] stamp, logic [31:0] slen,
                                       logic [31:0] blen, int trail);
    frame_bytes.delete();
    for (int i = 7; i >= 0; i--) add_byte(stamp[8*i +: 8]);
    for (int i = 3; i >= 0; i--) add_byte(slen[8*i +: 8]);
    for (int unsigned i = 0; i < slen && i < 24; i++)
      add_byte(8'($urandom()));
    for (int i = 3; i >= 0; i--) add_byte(blen[8*i +: 8]);
    for (int unsigned i = 0; i < blen && i < 24; i++)
      add_byte(8'($urandom()));
    for (int i = 0; i < trail; i++) add_byte(8'($urandom()));
  endfunction

  // Offers one byte in bursts with random gaps and waits for the transaction.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_byte(b, last);
    bytes_sent++;
  endtask

  // Sends the first cut bytes of the laid-out buffer, marking the final one.
  task automatic send_buffer(int cut);
    for (int i = 0; i < cut; i++) send_byte(frame_bytes[i], i == cut - 1);
    buffers_sent++;
  endtask

  // Receiver: changing stall patterns plus one long hold-off mid-run.
  initial begin
    rx_mode_t mode;
    int       cyc;
    mode = RX_OPEN;
    cyc  = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && bytes_sent >= 500) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (cyc % 128 == 0) mode = rx_mode_t'($urandom_range(0, 3));
        case (mode)
          RX_OPEN:       out_tready <= 1'b1;
          RX_COIN:       out_tready <= 1'($urandom_range(0, 1));
          RX_RARE_STALL: out_tready <= ($urandom_range(0, 9) != 0);
          default:       out_tready <= (cyc % 4 != 3);
        endcase
        cyc++;
      end
    end
  end

  // Checks every result transaction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_item(out_tuser[2:0], out_tdata, out_tuser[4:3], out_tlast);
  end

  // Stimulus: directed buffers, then random records, truncations and noise.
  initial begin
    int          pick;
    int          cut;
    logic [63:0] stamp;
    logic [31:0] slen;
    logic [31:0] blen;
    int          trail;
    int          marks[5];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Buffer of a single byte, a buffer that stops right after the timestamp,
    // and a minimal record with empty sender and body.
    build_record('1, '0, '0, 0);
    send_buffer(1);
    build_record('0, '0, '0, 0);
    send_buffer(8);
    build_record('1, '0, '0, 0);
    send_buffer(frame_bytes.size());

    while (bytes_sent < 1150) begin
      pick  = $urandom_range(0, 99);
      stamp = {$urandom(), $urandom()};
      slen  = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
      blen  = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
      trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      if (pick < 60) begin
        // Well-formed record, possibly with ignored trailing bytes.
        build_record(stamp, slen, blen, trail);
        send_buffer(frame_bytes.size());
      end else if (pick < 85) begin
        // Truncated record, often cut exactly at a field boundary; the cut may also keep the whole buffer.
        build_record(stamp, slen, blen, trail);
        marks = '{8, 12, 12 + int'(slen), 16 + int'(slen), frame_bytes.size()};
        if ($urandom_range(0, 1) == 0) cut = marks[$urandom_range(0, 4)];
        else cut = $urandom_range(1, frame_bytes.size());
        send_buffer(cut);
      end else if (pick < 93) begin
        // Full-range length that the buffer cannot hold.
        if ($urandom_range(0, 1) == 0) slen = $urandom();
        else blen = $urandom();
        build_record(stamp, slen, blen, 0);
        send_buffer($urandom_range(1, frame_bytes.size()));
      end else begin
        // Short noise buffer.
        frame_bytes.delete();
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom()));
        send_buffer(frame_bytes.size());
      end
    end
    in_tvalid <= 1'b0;

    while (tracker.expected_items.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d buffers; checked %0d results.",
             bytes_sent, buffers_sent, tracker.checked);
    $display("Results with an error code: %0d; completed records: %0d.",
             tracker.error_items, tracker.records_done);
    if (tracker.fails == 0 && tracker.expected_items.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
